// ===== src/iir_direct_form_two_filter_core_macros.svh =====
// Assertion helpers for the IIR core checker.
// Both expect clk_i and rst_ni in scope.
`ifndef IIR_DIRECT_FORM_TWO_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define IIR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iir core check failed");

// next-cycle implication
`define IIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iir core check failed");

`endif

// ===== src/iirdf2_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iirdf2_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int W_BITS        = 48;  // history word, Q32.16
  localparam int W_FRAC        = 16;
  localparam int COEF_BITS     = 32;  // Q4.28
  localparam int ACC_BITS      = 56;
  localparam int MAX_ORDER     = 4;
  localparam int ORD_BITS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int HALF_BITS     = 24;  // history word split for the multiplier
  localparam int OPND_BITS     = HALF_BITS + 1;
  localparam int PROD_BITS     = COEF_BITS + OPND_BITS;
  localparam int TERM_BITS     = 80;
  localparam int COEF_FRAC     = 28;

  localparam logic [TERM_BITS-1:0] TERM_RND = TERM_BITS'(1) << (COEF_FRAC - 1);
  localparam logic [ACC_BITS-1:0]  Y_RND    = ACC_BITS'(1) << (W_FRAC - 1);

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COEF_01 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COEF_23 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_COEF_4  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEN_COEF_12 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEN_COEF_34 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_ORD     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEN_ORD     = 3'd6;

  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          saturated;
  } out_item_t;

  typedef struct packed {
    logic [MAX_ORDER:0][COEF_BITS-1:0] b;
    logic [MAX_ORDER:1][COEF_BITS-1:0] a;
    logic [ORD_BITS-1:0]               nord;
    logic [ORD_BITS-1:0]               dord;
  } coef_t;

  typedef struct packed {
    logic                        vld;
    logic                        hi;
    logic                        neg;
    logic                        ld;
    logic signed [COEF_BITS-1:0] coef;
    logic signed [OPND_BITS-1:0] opnd;
    logic signed [ACC_BITS-1:0]  ld_val;
  } mac_op_t;

  typedef struct packed {
    logic                       busy;
    logic signed [ACC_BITS-1:0] acc;
  } mac_stat_t;

endpackage

`default_nettype wire

// ===== src/iirdf2_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared multiply-accumulate: one partial product per cycle, two per term.
// stage 1: coef * half word; stage 2: join halves and add rounding;
// stage 3: add or subtract the rounded term.
module iirdf2_mac (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iirdf2_pkg::mac_op_t   op_i,
  output iirdf2_pkg::mac_stat_t stat_o
);

  logic vld_q, hi_q, tv_q;
  logic neg_q, tneg_q;
  logic signed [iirdf2_pkg::PROD_BITS-1:0] prod_q, lo_q;
  logic signed [iirdf2_pkg::TERM_BITS-1:0] term_q, term_d;
  logic signed [iirdf2_pkg::ACC_BITS-1:0]  acc_q, acc_d, rterm;

  assign term_d = {{(iirdf2_pkg::TERM_BITS - iirdf2_pkg::PROD_BITS){lo_q[iirdf2_pkg::PROD_BITS-1]}},
                   lo_q}
                + {prod_q[iirdf2_pkg::TERM_BITS-iirdf2_pkg::HALF_BITS-1:0],
                   {iirdf2_pkg::HALF_BITS{1'b0}}}
                + iirdf2_pkg::TERM_RND;

  // floor((p + 2^27) / 2^28)
  assign rterm = {{(iirdf2_pkg::ACC_BITS - iirdf2_pkg::TERM_BITS + iirdf2_pkg::COEF_FRAC)
                   {term_q[iirdf2_pkg::TERM_BITS-1]}},
                  term_q[iirdf2_pkg::TERM_BITS-1:iirdf2_pkg::COEF_FRAC]};

  assign acc_d = tneg_q ? (acc_q - rterm) : (acc_q + rterm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hi_q  <= 1'b0;
      tv_q  <= 1'b0;
    end else begin
      vld_q <= op_i.vld;
      hi_q  <= op_i.hi;
      tv_q  <= vld_q & hi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_i.coef * op_i.opnd;
    neg_q  <= op_i.neg;
    if (vld_q && !hi_q) begin
      lo_q <= prod_q;
    end
    if (vld_q && hi_q) begin
      term_q <= term_d;
      tneg_q <= neg_q;
    end
    if (op_i.ld) begin
      acc_q <= op_i.ld_val;
    end else if (tv_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = vld_q | tv_q;
  assign stat_o.acc  = acc_q;

endmodule

`default_nettype wire

// ===== src/iirdf2_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: feeds denominator terms, then numerator terms, to the MAC,
// keeps the history and forms w0 and the output sample.
module iirdf2_seq #(
  parameter int ORDER = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  iirdf2_pkg::in_item_t  in_item_i,
  output logic                  idle_o,
  input  iirdf2_pkg::coef_t     cfg_i,
  input  logic                  out_ready_i,
  output logic                  done_o,
  output iirdf2_pkg::out_item_t res_o,
  output iirdf2_pkg::mac_op_t   op_o,
  input  iirdf2_pkg::mac_stat_t stat_i
);

  localparam int HIW = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam logic [iirdf2_pkg::ORD_BITS-1:0] ORD_MAX = iirdf2_pkg::ORD_BITS'(ORDER);
  localparam int SB = iirdf2_pkg::SAMPLE_BITS;
  localparam int AB = iirdf2_pkg::ACC_BITS;
  localparam int WB = iirdf2_pkg::W_BITS;
  localparam int YB = AB - iirdf2_pkg::W_FRAC;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_DEN       = 3'd1;
  localparam logic [2:0] ST_DEN_DRAIN = 3'd2;
  localparam logic [2:0] ST_NUM       = 3'd3;
  localparam logic [2:0] ST_NUM_DRAIN = 3'd4;

  localparam logic [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
  localparam logic [SB-1:0] Y_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] Y_MIN = {1'b1, {(SB-1){1'b0}}};

  logic [2:0] state_q, state_d;
  logic [iirdf2_pkg::ORD_BITS-1:0] idx_q, idx_d, nord_q, dord_q, nord_cl, dord_cl;
  logic half_q, half_d;
  logic [ORDER-1:0][WB-1:0] hist_q;
  logic [WB-1:0] w0_q, w0_sat, wsel;
  logic w0sat_q, w0_ovf, w0_ld, hist_clr, hist_shift, start;
  logic [HIW-1:0] hidx;
  logic [AB-1:0] y_sum;
  logic [YB-1:0] y_int;
  logic y_ovf;

  assign nord_cl = (cfg_i.nord > ORD_MAX) ? ORD_MAX : cfg_i.nord;
  assign dord_cl = (cfg_i.dord > ORD_MAX) ? ORD_MAX : cfg_i.dord;

  assign hidx = (idx_q == '0) ? '0 : HIW'(idx_q - 3'd1);
  assign wsel = (state_q == ST_NUM && idx_q == '0) ? w0_q : hist_q[hidx];

  // w0 clip to 48 bits
  assign w0_ovf = !((&stat_i.acc[AB-1:WB-1]) || !(|stat_i.acc[AB-1:WB-1]));
  assign w0_sat = w0_ovf ? (stat_i.acc[AB-1] ? W_MIN : W_MAX) : stat_i.acc[WB-1:0];

  // y: round half up to integer, then clip
  assign y_sum = stat_i.acc + iirdf2_pkg::Y_RND;
  assign y_int = y_sum[AB-1:iirdf2_pkg::W_FRAC];
  assign y_ovf = !((&y_int[YB-1:SB-1]) || !(|y_int[YB-1:SB-1]));

  assign res_o.filtered  = y_ovf ? (y_int[YB-1] ? Y_MIN : Y_MAX) : y_int[SB-1:0];
  assign res_o.saturated = y_ovf | w0sat_q;

  assign idle_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    half_d     = half_q;
    start      = 1'b0;
    w0_ld      = 1'b0;
    hist_clr   = 1'b0;
    hist_shift = 1'b0;
    done_o     = 1'b0;
    op_o.vld    = 1'b0;
    op_o.hi     = half_q;
    op_o.neg    = (state_q == ST_DEN);
    op_o.ld     = 1'b0;
    op_o.ld_val = '0;
    op_o.coef   = (state_q == ST_NUM) ? cfg_i.b[idx_q] : cfg_i.a[idx_q];
    op_o.opnd   = half_q ? {wsel[WB-1], wsel[WB-1:iirdf2_pkg::HALF_BITS]}
                         : {1'b0, wsel[iirdf2_pkg::HALF_BITS-1:0]};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.action) begin
            hist_clr = 1'b1;
          end else begin
            start       = 1'b1;
            op_o.ld     = 1'b1;
            op_o.ld_val = {{(AB-SB-iirdf2_pkg::W_FRAC){in_item_i.sample[SB-1]}},
                           in_item_i.sample, {iirdf2_pkg::W_FRAC{1'b0}}};
            idx_d       = 3'd1;
            half_d      = 1'b0;
            state_d     = (dord_cl == '0) ? ST_DEN_DRAIN : ST_DEN;
          end
        end
      end
      ST_DEN: begin
        op_o.vld = 1'b1;
        half_d   = ~half_q;
        if (half_q) begin
          if (idx_q == dord_q) state_d = ST_DEN_DRAIN;
          else idx_d = idx_q + 3'd1;
        end
      end
      ST_DEN_DRAIN: begin
        if (!stat_i.busy) begin
          w0_ld   = 1'b1;
          op_o.ld = 1'b1;
          idx_d   = '0;
          half_d  = 1'b0;
          state_d = ST_NUM;
        end
      end
      ST_NUM: begin
        op_o.vld = 1'b1;
        half_d   = ~half_q;
        if (half_q) begin
          if (idx_q == nord_q) state_d = ST_NUM_DRAIN;
          else idx_d = idx_q + 3'd1;
        end
      end
      ST_NUM_DRAIN: begin
        if (!stat_i.busy && out_ready_i) begin
          done_o     = 1'b1;
          hist_shift = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      half_q  <= 1'b0;
      nord_q  <= '0;
      dord_q  <= '0;
      hist_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      half_q  <= half_d;
      if (start) begin
        nord_q <= nord_cl;
        dord_q <= dord_cl;
      end
      if (hist_clr) begin
        hist_q <= '0;
      end else if (hist_shift) begin
        for (int i = ORDER - 1; i > 0; i--) begin
          hist_q[i] <= hist_q[i-1];
        end
        hist_q[0] <= w0_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (w0_ld) begin
      w0_q    <= w0_sat;
      w0sat_q <= w0_ovf;
    end
  end

endmodule

`default_nettype wire

// ===== src/iir_direct_form_two_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Direct form II IIR section, one shared 32x25 multiplier, two partial products per term.
// Items are handled one at a time: the input stalls from acceptance until the result is
//   passed to the output register, and a clear item leaves the input free.
// Result timing is set by the MAC pipeline depth (3) drained twice and the serial terms,
//   whose number follows nord and dord, the clamped orders.
// Reset (rst_ni low, async): history zero, registers to defaults (b0 = 1.0), no result pending.

module iir_direct_form_two_filter_core #(
  parameter int ORDER = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample items
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  iirdf2_pkg::in_item_t                  in_data_i,
  // filtered items
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output iirdf2_pkg::out_item_t                 out_data_o,
  // register writes
  input  logic                                  cfg_we_i,
  input  logic [iirdf2_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [iirdf2_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  localparam int CB = iirdf2_pkg::COEF_BITS;
  localparam int OB = iirdf2_pkg::ORD_BITS;

  // coefficient and order registers
  logic [2*CB-1:0] num01_q, num23_q, den12_q, den34_q;
  logic [CB-1:0]   num4_q;
  logic [OB-1:0]   nord_q, dord_q;

  iirdf2_pkg::coef_t     cfg;
  iirdf2_pkg::mac_op_t   mac_op;
  iirdf2_pkg::mac_stat_t mac_stat;
  iirdf2_pkg::out_item_t res;
  logic                  idle, done, out_ready;
  logic                  out_valid_q;
  iirdf2_pkg::out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num01_q <= 64'h0000_0000_1000_0000;  // b0 = 1.0
      num23_q <= '0;
      num4_q  <= '0;
      den12_q <= '0;
      den34_q <= '0;
      nord_q  <= '0;
      dord_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iirdf2_pkg::CFG_NUM_COEF_01: num01_q <= cfg_wdata_i;
        iirdf2_pkg::CFG_NUM_COEF_23: num23_q <= cfg_wdata_i;
        iirdf2_pkg::CFG_NUM_COEF_4:  num4_q  <= cfg_wdata_i[CB-1:0];
        iirdf2_pkg::CFG_DEN_COEF_12: den12_q <= cfg_wdata_i;
        iirdf2_pkg::CFG_DEN_COEF_34: den34_q <= cfg_wdata_i;
        iirdf2_pkg::CFG_NUM_ORD:     nord_q  <= cfg_wdata_i[OB-1:0];
        iirdf2_pkg::CFG_DEN_ORD:     dord_q  <= cfg_wdata_i[OB-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  assign cfg.b    = {num4_q, num23_q, num01_q};
  assign cfg.a    = {den34_q, den12_q};
  assign cfg.nord = nord_q;
  assign cfg.dord = dord_q;

  // item waits in the output register while the next one is computed
  assign out_ready = !out_valid_q || !out_stall_i;

  iirdf2_seq #(
    .ORDER(ORDER)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_data_i),
    .idle_o      (idle),
    .cfg_i       (cfg),
    .out_ready_i (out_ready),
    .done_o      (done),
    .res_o       (res),
    .op_o        (mac_op),
    .stat_i      (mac_stat)
  );

  iirdf2_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .stat_o (mac_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= done | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= res;
    end
  end

  assign in_stall_o  = !idle;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/iirdf2_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "iir_direct_form_two_filter_core_macros.svh"

// Port-level checks for the IIR core.
module iirdf2_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input iirdf2_pkg::in_item_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input iirdf2_pkg::out_item_t out_data_o
);

  // waiting item holds
  `IIR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // a filter item keeps the block busy on the next cycle
  `IIR_ASSERT_NEXT(a_busy_after_filter, in_valid_i && !in_stall_o && !in_data_i.action, in_stall_o)

  // a clear item produces nothing and frees the input at once
  `IIR_ASSERT_NEXT(a_clear_quiet, in_valid_i && !in_stall_o && in_data_i.action, !in_stall_o && !$rose(out_valid_o))

  // a new result only ends a busy period
  `IIR_ASSERT_SAME(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind iir_direct_form_two_filter_core iirdf2_chk u_chk (.*);

`default_nettype wire
